FILE: design/assert_macros.svh
// Assertion macros included by pso_particle_update
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pso_pkg.sv
// ----------------------------------------------------------------------------
// pso_pkg
// Opcodes, register indexes, reset values, transaction and controller types.
// ----------------------------------------------------------------------------
package pso_pkg;

  localparam int OPCODE_W = 3;
  localparam int DIM_W    = 4;
  localparam int GAIN_W   = 16;
  localparam int RAND_W   = 16;
  localparam int FIT_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_G   = 12;

  localparam logic [OPCODE_W-1:0] OP_LOAD     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_MOVE     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_FITNESS  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_NFITNESS = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_NELEMENT = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_READ     = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_COG   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHI   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VFLR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VCEIL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PFLR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PCEIL = 3'd6;

  localparam logic [GAIN_W-1:0] COG_RESET = 16'd8397;
  localparam logic [GAIN_W-1:0] SOC_RESET = 16'd8397;
  localparam logic [GAIN_W-1:0] CHI_RESET = 16'd2989;
  localparam longint VFLR_RESET  = -655360;
  localparam longint VCEIL_RESET = 655360;
  localparam longint PFLR_RESET  = 0;
  localparam longint PCEIL_RESET = 6553600;

  // datapath step commands
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_MUL1  = 3'd2;
  localparam logic [2:0] CMD_MUL2  = 3'd3;
  localparam logic [2:0] CMD_WRITE = 3'd4;
  localparam logic [2:0] CMD_COPY  = 3'd5;
  localparam logic [2:0] CMD_RESULT = 3'd6;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [DIM_W-1:0]          dim_index;
    logic signed [VALUE_W-1:0] value_a;
    logic signed [VALUE_W-1:0] value_b;
    logic [RAND_W-1:0]         rand_one;
    logic [RAND_W-1:0]         rand_two;
    logic [FIT_W-1:0]          fitness_value;
  } pso_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] position_out;
    logic signed [VALUE_W-1:0] velocity_out;
    logic signed [VALUE_W-1:0] best_out;
    logic                      improved;
    logic                      rejected;
  } pso_out_t;

  typedef struct packed {
    logic [2:0] step;
  } pso_cmd_t;

  typedef struct packed {
    logic copy_last;
  } pso_status_t;

endpackage

FILE: design/pso_stream_if.sv
// ----------------------------------------------------------------------------
// pso_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface pso_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/pso_ctrl.sv
// ----------------------------------------------------------------------------
// pso_ctrl
// Sequencer for one transaction: fetch, multiply steps or copy sweep, write, result.
// ----------------------------------------------------------------------------
module pso_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [2:0]           in_opcode,
  input  logic                 copy_needed,
  input  logic                 out_busy,
  input  pso_pkg::pso_status_t status,
  output logic                 in_ready,
  output pso_pkg::pso_cmd_t    cmd
);
  import pso_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_COPY  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       is_move;

  assign in_ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      is_move <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        is_move <= (in_opcode == OP_MOVE);
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd.step = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.step = CMD_READ;
        if (is_move) begin
          state_next = S_MUL1;
        end else if (copy_needed) begin
          state_next = S_COPY;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_MUL1: begin
        cmd.step = CMD_MUL1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.step = CMD_MUL2;
        state_next = S_WRITE;
      end
      S_COPY: begin
        cmd.step = CMD_COPY;
        if (status.copy_last) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.step = CMD_WRITE;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.step = CMD_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

FILE: design/pso_datapath.sv
// ----------------------------------------------------------------------------
// pso_datapath
// Vector stores, fitness registers, update arithmetic and the result register.
// ----------------------------------------------------------------------------
module pso_datapath #(
  parameter int DIMENSIONS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_take,
  input  logic [2:0]                           in_opcode,
  input  logic [3:0]                           in_dim,
  input  logic signed [pso_pkg::VALUE_W-1:0]   in_a,
  input  logic signed [pso_pkg::VALUE_W-1:0]   in_b,
  input  logic [15:0]                          in_r1,
  input  logic [15:0]                          in_r2,
  input  logic [31:0]                          in_fit,
  input  logic                                 cfg_we,
  input  logic [2:0]                           cfg_idx,
  input  logic [pso_pkg::VALUE_W-1:0]          cfg_data,
  input  pso_pkg::pso_cmd_t                    cmd,
  output pso_pkg::pso_status_t                 status,
  output logic                                 copy_needed,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pso_pkg::VALUE_W-1:0]   out_pos,
  output logic signed [pso_pkg::VALUE_W-1:0]   out_vel,
  output logic signed [pso_pkg::VALUE_W-1:0]   out_best,
  output logic                                 out_improved,
  output logic                                 out_rejected
);
  import pso_pkg::*;

  localparam int AW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int DW = VALUE_W + 2;
  localparam int PW = DW + 17;
  localparam int VW = PW + 2;
  localparam int CW = VW + 17;

  logic signed [VALUE_W-1:0] pos_mem [DIMENSIONS];
  logic signed [VALUE_W-1:0] vel_mem [DIMENSIONS];
  logic signed [VALUE_W-1:0] pb_mem  [DIMENSIONS];
  logic signed [VALUE_W-1:0] nb_mem  [DIMENSIONS];

  logic [15:0] cog, soc, chi;
  logic signed [VALUE_W-1:0] vflr, vceil, pflr, pceil;
  logic [31:0] best_fit, nbr_fit;
  logic        nbr_open;

  logic [2:0]  op;
  logic [3:0]  dim;
  logic        dvalid;
  logic signed [VALUE_W-1:0] va, vb;
  logic [15:0] r1, r2;
  logic [31:0] fit;

  logic signed [VALUE_W-1:0] x, v, pb, nb;
  logic signed [PW-1:0] t1, t2;
  logic signed [VW-1:0] vsum;
  logic signed [CW-1:0] vprod;
  logic [AW-1:0] addr;
  logic [AW-1:0] copy_ptr;
  logic          improved, rejected;

  logic [31:0] g1_full, g2_full;
  logic signed [16:0] g1, g2;
  logic signed [DW-1:0] d1, d2;
  logic signed [VW-1:0] vscaled;
  logic signed [VW-1:0] vclamp;
  logic signed [VW-1:0] xsum;
  logic signed [VALUE_W-1:0] xnew, vnew;
  logic          xhit;

  assign addr = AW'(dim);
  assign dvalid = ({28'd0, dim} < 32'(DIMENSIONS));
  assign copy_needed = (op == OP_FITNESS) && (fit != 32'd0) && (fit > best_fit);
  assign status.copy_last = (copy_ptr == AW'(DIMENSIONS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cog <= COG_RESET;
      soc <= SOC_RESET;
      chi <= CHI_RESET;
      vflr <= VALUE_W'(VFLR_RESET);
      vceil <= VALUE_W'(VCEIL_RESET);
      pflr <= VALUE_W'(PFLR_RESET);
      pceil <= VALUE_W'(PCEIL_RESET);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_COG:   cog <= cfg_data[15:0];
        REG_SOC:   soc <= cfg_data[15:0];
        REG_CHI:   chi <= cfg_data[15:0];
        REG_VFLR:  vflr <= cfg_data;
        REG_VCEIL: vceil <= cfg_data;
        REG_PFLR:  pflr <= cfg_data;
        REG_PCEIL: pceil <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op <= in_opcode;
      dim <= in_dim;
      va <= in_a;
      vb <= in_b;
      r1 <= in_r1;
      r2 <= in_r2;
      fit <= in_fit;
    end
  end

  // gains, one product each
  always_comb begin
    g1_full = 32'(cog) * 32'(r1);
    g2_full = 32'(soc) * 32'(r2);
  end

  always_ff @(posedge clk) begin
    if (cmd.step == CMD_READ) begin
      x <= pos_mem[addr];
      v <= vel_mem[addr];
      pb <= pb_mem[addr];
      nb <= nb_mem[addr];
      g1 <= {1'b0, g1_full[31:16]};
      g2 <= {1'b0, g2_full[31:16]};
    end
  end

  always_comb begin
    d1 = DW'(pb) - DW'(x);
    d2 = DW'(nb) - DW'(x);
    vsum = VW'(v) + VW'(t1) + VW'(t2);
  end

  always_comb begin
    vscaled = VW'(vprod >>> FRAC_G);
    if (vscaled < VW'(vflr)) begin
      vclamp = VW'(vflr);
    end else if (vscaled > VW'(vceil)) begin
      vclamp = VW'(vceil);
    end else begin
      vclamp = vscaled;
    end
    xsum = VW'(x) + vclamp;
    xhit = 1'b1;
    if (xsum < VW'(pflr)) begin
      xnew = pflr;
    end else if (xsum > VW'(pceil)) begin
      xnew = pceil;
    end else begin
      xnew = VALUE_W'(xsum);
      xhit = 1'b0;
    end
    vnew = xhit ? '0 : VALUE_W'(vclamp);
  end

  always_ff @(posedge clk) begin
    if (cmd.step == CMD_MUL1) begin
      t1 <= PW'((PW'(g1) * PW'(d1)) >>> FRAC_G);
      t2 <= PW'((PW'(g2) * PW'(d2)) >>> FRAC_G);
    end
    if (cmd.step == CMD_MUL2) begin
      vprod <= CW'(vsum) * CW'($signed({1'b0, chi}));
    end
  end

  // copy sweep: position into personal best
  always_ff @(posedge clk) begin
    if (cmd.step == CMD_READ) begin
      copy_ptr <= '0;
    end else if (cmd.step == CMD_COPY) begin
      copy_ptr <= copy_ptr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == CMD_COPY) begin
      pb_mem[copy_ptr] <= pos_mem[copy_ptr];
    end
    if (cmd.step == CMD_WRITE && dvalid) begin
      if (op == OP_LOAD) begin
        pos_mem[addr] <= va;
        vel_mem[addr] <= vb;
      end else if (op == OP_MOVE) begin
        pos_mem[addr] <= xnew;
        vel_mem[addr] <= vnew;
      end else if (op == OP_NELEMENT && nbr_open) begin
        nb_mem[addr] <= va;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_fit <= '0;
      nbr_fit <= '0;
      nbr_open <= 1'b0;
      improved <= 1'b0;
      rejected <= 1'b0;
    end else if (cmd.step == CMD_WRITE) begin
      improved <= 1'b0;
      rejected <= 1'b0;
      if (op == OP_FITNESS) begin
        if (fit == 32'd0) begin
          rejected <= 1'b1;
        end else if (fit > best_fit) begin
          best_fit <= fit;
          improved <= 1'b1;
        end
      end else if (op == OP_NFITNESS) begin
        if (fit > nbr_fit) begin
          nbr_fit <= fit;
          nbr_open <= 1'b1;
          improved <= 1'b1;
        end else begin
          nbr_open <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step == CMD_RESULT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step == CMD_RESULT) begin
      out_pos <= dvalid ? pos_mem[addr] : '0;
      out_vel <= dvalid ? vel_mem[addr] : '0;
      out_best <= (dvalid && op == OP_READ) ? pb_mem[addr] : '0;
      out_improved <= improved;
      out_rejected <= rejected;
    end
  end
endmodule

FILE: design/pso_particle_update.sv
// ----------------------------------------------------------------------------
// pso_particle_update
// One swarm particle with constriction-factor velocity and position update.
// ----------------------------------------------------------------------------
// A transaction steps from accept through the store read, the write and the
// result state back to idle (load, fitness without copy, neighbor, read and
// unused opcodes). A move adds two registered multiply steps after the store
// read, which also forms the gains; an improving fitness adds a sweep that
// copies the position store into the personal best one entry a cycle. One
// transaction is in work at a time; the result register lets the next one
// start while a result waits to be taken, and that transaction holds in its
// result state until the register frees. Input ready is low during reset.
module pso_particle_update #(
  parameter int DIMENSIONS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  pso_stream_if.sink                      in_ch,
  pso_stream_if.source                    out_ch,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [pso_pkg::VALUE_W-1:0]     cfg_data
);
  import pso_pkg::*;
  `include "assert_macros.svh"

  pso_cmd_t    cmd;
  pso_status_t status;
  logic        copy_needed;
  logic        take;
  logic        out_valid;

  assign take = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;

  pso_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_ch.valid),
    .in_opcode(in_ch.payload.opcode),
    .copy_needed(copy_needed),
    .out_busy(out_valid && !out_ch.ready),
    .status(status),
    .in_ready(in_ch.ready),
    .cmd(cmd)
  );

  pso_datapath #(
    .DIMENSIONS(DIMENSIONS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .in_take(take),
    .in_opcode(in_ch.payload.opcode),
    .in_dim(in_ch.payload.dim_index),
    .in_a(in_ch.payload.value_a),
    .in_b(in_ch.payload.value_b),
    .in_r1(in_ch.payload.rand_one),
    .in_r2(in_ch.payload.rand_two),
    .in_fit(in_ch.payload.fitness_value),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd),
    .status(status),
    .copy_needed(copy_needed),
    .out_valid(out_valid),
    .out_ready(out_ch.ready),
    .out_pos(out_ch.payload.position_out),
    .out_vel(out_ch.payload.velocity_out),
    .out_best(out_ch.payload.best_out),
    .out_improved(out_ch.payload.improved),
    .out_rejected(out_ch.payload.rejected)
  );

  `ASSERT_NEXT(a_take_leaves_idle, clk, rst, take, !in_ch.ready, "ready stayed high after take")
  `ASSERT_IMPLY(a_flags_exclusive, clk, rst, out_valid,
    !(out_ch.payload.improved && out_ch.payload.rejected), "improved and rejected together")
  `ASSERT_IMPLY(a_no_take_in_copy, clk, rst, cmd.step == CMD_COPY, !in_ch.ready,
    "input accepted during copy sweep")
endmodule

FILE: bench/tb_pso_particle_update.sv
// ----------------------------------------------------------------------------
// tb_pso_particle_update
// Self-checking bench for one swarm particle: a queue-fed driver offers
// commands, a clocked monitor predicts each accepted transaction and compares
// every returned result as a whole, across several gain/limit settings
// and several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pso_particle_update;
  import pso_pkg::*;

  localparam int NUM_DIMS   = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef pso_in_t  particle_cmd_t;
  typedef pso_out_t particle_res_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  pso_stream_if #(.payload_t(particle_cmd_t)) cmd_ch ();
  pso_stream_if #(.payload_t(particle_res_t)) res_ch ();

  pso_particle_update #(.DIMENSIONS(NUM_DIMS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (cmd_ch.sink),
    .out_ch   (res_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // shadow of the particle
  logic [15:0] cog_gain, soc_gain, chi_gain;
  longint      vel_lo, vel_hi, pos_lo, pos_hi;
  longint      pos_mem [NUM_DIMS];
  longint      vel_mem [NUM_DIMS];
  longint      pbest_mem [NUM_DIMS];
  longint      nbest_mem [NUM_DIMS];
  logic [31:0] own_best_fit, nbr_best_fit;
  bit          nbr_open;

  particle_cmd_t cmd_pending [$];
  particle_res_t res_expected [$];

  int  idle_pct, stall_pct;
  int  hold_left;
  int  hold_reqs;
  int  hold_seen;
  bit  cmd_taken;
  int  mismatches = 0;
  int  results_seen = 0;
  int  improves_seen = 0;
  int  moves_sent;
  int  cycles = 0;

  logic [31:0] gen_own_fit, gen_nbr_fit;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void queue_cmd(particle_cmd_t c);
    cmd_pending.insert(cmd_pending.size(), c);
  endfunction

  function automatic particle_res_t predict_particle(particle_cmd_t c);
    particle_res_t r;
    int     d;
    longint x, v, g1, g2, t1, t2, nx;
    bit     hit;
    d = c.dim_index;
    r = '0;
    case (c.opcode)
      OP_LOAD: begin
        pos_mem[d] = longint'(c.value_a);
        vel_mem[d] = longint'(c.value_b);
      end
      OP_MOVE: begin
        x  = pos_mem[d];
        g1 = (longint'(cog_gain) * longint'(c.rand_one)) >>> 16;
        g2 = (longint'(soc_gain) * longint'(c.rand_two)) >>> 16;
        t1 = (g1 * (pbest_mem[d] - x)) >>> 12;
        t2 = (g2 * (nbest_mem[d] - x)) >>> 12;
        v  = vel_mem[d] + t1 + t2;
        v  = (v * longint'(chi_gain)) >>> 12;
        if (v < vel_lo) v = vel_lo;
        else if (v > vel_hi) v = vel_hi;
        nx  = x + v;
        hit = 1'b1;
        if (nx < pos_lo) nx = pos_lo;
        else if (nx > pos_hi) nx = pos_hi;
        else hit = 1'b0;
        if (hit) v = 0;
        pos_mem[d] = nx;
        vel_mem[d] = v;
      end
      OP_FITNESS: begin
        if (c.fitness_value == 32'd0) begin
          r.rejected = 1'b1;
        end else if (c.fitness_value > own_best_fit) begin
          own_best_fit = c.fitness_value;
          for (int i = 0; i < NUM_DIMS; i++) pbest_mem[i] = pos_mem[i];
          r.improved = 1'b1;
        end
      end
      OP_NFITNESS: begin
        if (c.fitness_value > nbr_best_fit) begin
          nbr_best_fit = c.fitness_value;
          nbr_open     = 1'b1;
          r.improved   = 1'b1;
        end else begin
          nbr_open = 1'b0;
        end
      end
      OP_NELEMENT: begin
        if (nbr_open) nbest_mem[d] = longint'(c.value_a);
      end
      OP_READ: begin
        r.best_out = pbest_mem[d][31:0];
      end
      default: begin
      end
    endcase
    r.position_out = pos_mem[d][31:0];
    r.velocity_out = vel_mem[d][31:0];
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid   <= 1'b0;
      cmd_ch.payload <= '0;
    end else if (!cmd_ch.valid || cmd_taken) begin
      if (cmd_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cmd_ch.payload <= cmd_pending.pop_front();
        cmd_ch.valid   <= 1'b1;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // receiver readiness, with a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_seen    <= 0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen    <= hold_reqs;
      hold_left    <= 400;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    particle_res_t want;
    particle_res_t got;
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= cmd_ch.valid && cmd_ch.ready;
      if (cmd_ch.valid && cmd_ch.ready) begin
        res_expected.insert(res_expected.size(), predict_particle(cmd_ch.payload));
      end
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.payload;
        results_seen++;
        if (got.improved) improves_seen++;
        if (res_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result %p", $realtime, got);
        end else begin
          want = res_expected.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"[%0t] mismatch: exp pos=%0d vel=%0d best=%0d imp=%0b rej=%0b,",
                        " got pos=%0d vel=%0d best=%0d imp=%0b rej=%0b"},
                       $realtime, want.position_out, want.velocity_out, want.best_out,
                       want.improved, want.rejected, got.position_out, got.velocity_out,
                       got.best_out, got.improved, got.rejected);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", res_expected.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COG:   cog_gain = data[15:0];
      REG_SOC:   soc_gain = data[15:0];
      REG_CHI:   chi_gain = data[15:0];
      REG_VFLR:  vel_lo = longint'($signed(data));
      REG_VCEIL: vel_hi = longint'($signed(data));
      REG_PFLR:  pos_lo = longint'($signed(data));
      REG_PCEIL: pos_hi = longint'($signed(data));
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [15:0] c1, logic [15:0] c2, logic [15:0] chi,
                            logic [31:0] vlo, logic [31:0] vhi,
                            logic [31:0] plo, logic [31:0] phi);
    write_reg(REG_COG, {16'd0, c1});
    write_reg(REG_SOC, {16'd0, c2});
    write_reg(REG_CHI, {16'd0, chi});
    write_reg(REG_VFLR, vlo);
    write_reg(REG_VCEIL, vhi);
    write_reg(REG_PFLR, plo);
    write_reg(REG_PCEIL, phi);
  endtask

  function automatic particle_cmd_t make_cmd(logic [2:0] op, int d, logic [31:0] a,
                                             logic [31:0] fit);
    particle_cmd_t c;
    c.opcode        = op;
    c.dim_index     = d[3:0];
    c.value_a       = a;
    c.value_b       = $urandom();
    c.rand_one      = 16'($urandom());
    c.rand_two      = 16'($urandom());
    c.fitness_value = fit;
    return c;
  endfunction

  function automatic logic [31:0] rising_fit(logic [31:0] cur);
    logic [31:0] step;
    step = $urandom_range(1, 5000);
    return (cur > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : cur + step;
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(3) == 0) return $urandom();
    return $signed($urandom_range(0, 20000000)) - 32'sd10000000;
  endfunction

  task automatic queue_random(int n);
    particle_cmd_t c;
    int sel, burst;
    while (n > 0) begin
      sel = $urandom_range(99);
      if (sel < 14) begin
        c = make_cmd(OP_LOAD, $urandom_range(15), pick_value(), $urandom());
        c.value_b = pick_value();
        queue_cmd(c);
        n--;
      end else if (sel < 54) begin
        queue_cmd(make_cmd(OP_MOVE, $urandom_range(15), $urandom(), $urandom()));
        moves_sent++;
        n--;
      end else if (sel < 66) begin
        if ($urandom_range(1)) gen_own_fit = rising_fit(gen_own_fit);
        queue_cmd(make_cmd(OP_FITNESS, $urandom_range(15), $urandom(),
                           $urandom_range(4) == 0 ? 32'd0 : gen_own_fit));
        n--;
      end else if (sel < 82) begin
        // neighbor offer followed by its elements
        if ($urandom_range(3) != 0) gen_nbr_fit = rising_fit(gen_nbr_fit);
        queue_cmd(make_cmd(OP_NFITNESS, $urandom_range(15), $urandom(), gen_nbr_fit));
        burst = $urandom_range(1, 5);
        for (int i = 0; i < burst; i++)
          queue_cmd(make_cmd(OP_NELEMENT, $urandom_range(15), pick_value(), $urandom()));
        n -= burst + 1;
      end else if (sel < 90) begin
        queue_cmd(make_cmd(OP_NELEMENT, $urandom_range(15), $urandom(), $urandom()));
        n--;
      end else if (sel < 98) begin
        queue_cmd(make_cmd(OP_READ, $urandom_range(15), $urandom(), $urandom()));
        n--;
      end else begin
        queue_cmd(make_cmd($urandom_range(1) ? OP_SPARE6 : OP_SPARE7,
                           $urandom_range(15), $urandom(), $urandom()));
        n--;
      end
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (cmd_pending.size() > 0 || cmd_ch.valid || res_expected.size() > 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    particle_cmd_t c;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_reqs = 0;
    idle_pct = 0;
    stall_pct = 0;
    moves_sent = 0;
    cog_gain = COG_RESET;
    soc_gain = SOC_RESET;
    chi_gain = CHI_RESET;
    vel_lo = VFLR_RESET;
    vel_hi = VCEIL_RESET;
    pos_lo = PFLR_RESET;
    pos_hi = PCEIL_RESET;
    own_best_fit = '0;
    nbr_best_fit = '0;
    nbr_open = 1'b0;
    for (int i = 0; i < NUM_DIMS; i++) begin
      pos_mem[i] = 0; vel_mem[i] = 0; pbest_mem[i] = 0; nbest_mem[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // phase 0: reset settings, directed opening, no idling
    for (int i = 0; i < NUM_DIMS; i++) begin
      c = make_cmd(OP_LOAD, i, i == 0 ? 32'h7FFF_FFFF : i == 1 ? 32'h8000_0000 :
                   i == 2 ? 32'd0 : pick_value(), $urandom());
      c.value_b = i == 0 ? 32'h8000_0000 : i == 1 ? 32'h7FFF_FFFF : pick_value();
      queue_cmd(c);
    end
    queue_cmd(make_cmd(OP_FITNESS, 3, $urandom(), 32'd0));
    queue_cmd(make_cmd(OP_FITNESS, 4, $urandom(), 32'd1));
    queue_cmd(make_cmd(OP_FITNESS, 4, $urandom(), 32'd1));
    queue_cmd(make_cmd(OP_NFITNESS, 5, $urandom(), 32'd1));
    for (int i = 0; i < NUM_DIMS; i++)
      queue_cmd(make_cmd(OP_NELEMENT, i, pick_value(), $urandom()));
    queue_cmd(make_cmd(OP_READ, 0, $urandom(), $urandom()));
    c = make_cmd(OP_MOVE, 2, $urandom(), $urandom());
    c.rand_one = 16'hFFFF; c.rand_two = 16'h0000;
    queue_cmd(c);
    queue_cmd(make_cmd(OP_MOVE, 0, $urandom(), $urandom()));
    queue_cmd(make_cmd(OP_SPARE6, 6, $urandom(), $urandom()));
    queue_cmd(make_cmd(OP_SPARE7, 15, $urandom(), $urandom()));
    queue_cmd(make_cmd(OP_NFITNESS, 7, $urandom(), 32'd1));
    queue_cmd(make_cmd(OP_NELEMENT, 8, $urandom(), $urandom()));
    gen_own_fit = 32'd1;
    gen_nbr_fit = 32'd1;
    queue_random(70);
    drain();

    // phase 1: widest gains and limits, sender idling, receiver hold-off
    set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF);
    idle_pct = 73; stall_pct = 0;
    queue_random(110);
    repeat (20) @(posedge clk);
    hold_reqs = hold_reqs + 1;
    drain();

    // phase 2: zero gains, crossed limits, receiver stalling
    set_limits(16'h0000, 16'h0000, 16'h0000, 32'h0001_0000, 32'hFFFF_0000,
               32'h0005_0000, 32'hFFFB_0000);
    idle_pct = 0; stall_pct = 73;
    queue_random(100);
    drain();

    // phase 3: random settings, both sides idling
    set_limits(16'($urandom()), 16'($urandom()), 16'($urandom_range(2000, 6000)),
               -$urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h0100_0000),
               -$urandom_range(0, 32'h1000_0000), $urandom_range(0, 32'h1000_0000));
    idle_pct = 36; stall_pct = 36;
    queue_random(120);
    drain();

    // phase 4: back to reset settings, top fitness values at the end
    set_limits(COG_RESET, SOC_RESET, CHI_RESET, 32'(VFLR_RESET), 32'(VCEIL_RESET),
               32'(PFLR_RESET), 32'(PCEIL_RESET));
    idle_pct = 0; stall_pct = 0;
    queue_random(110);
    queue_cmd(make_cmd(OP_FITNESS, 9, $urandom(), 32'hFFFF_FFFF));
    queue_cmd(make_cmd(OP_NFITNESS, 10, $urandom(), 32'hFFFF_FFFF));
    queue_cmd(make_cmd(OP_NELEMENT, 11, 32'h7FFF_FFFF, $urandom()));
    queue_cmd(make_cmd(OP_READ, 9, $urandom(), $urandom()));
    drain();

    $display("covered %0d results (%0d moves, %0d improvements) over five settings",
             results_seen, moves_sent, improves_seen);
    $display("idling mixes: none, sender, receiver, both; one long receiver hold-off");
    if (mismatches == 0 && res_expected.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, res_expected.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/pso_pkg.sv
design/pso_stream_if.sv
design/pso_ctrl.sv
design/pso_datapath.sv
design/pso_particle_update.sv
bench/tb_pso_particle_update.sv
